// ----- sv/rtccal_pkg.sv -----
`timescale 1ns / 1ps

package rtccal_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_BEGIN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FAST_MODE     = 2'd0;
    localparam logic [1:0] CFG_NORMAL_PERIOD = 2'd1;
    localparam logic [1:0] CFG_FAST_PERIOD   = 2'd2;
    localparam logic [1:0] CFG_TICKS_PER_SEC = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int PERIOD_W   = 21;
    localparam int PRESCALE_W = 11;
    localparam int FIELD_W    = 7;
    localparam int YEAR_W     = 14;
    localparam int POS_W      = 5;

    // reset values
    localparam logic [PERIOD_W-1:0]   RST_NORMAL_PERIOD = 21'd1800000;
    localparam logic [PERIOD_W-1:0]   RST_FAST_PERIOD   = 21'd1000;
    localparam logic [PRESCALE_W-1:0] RST_TICKS_PER_SEC = 11'd1800;
    localparam logic [FIELD_W-1:0]    RST_DAY           = 7'd14;
    localparam logic [FIELD_W-1:0]    RST_MONTH         = 7'd4;
    localparam logic [YEAR_W-1:0]     RST_YEAR          = 14'd2023;

    // cursor positions
    localparam logic [POS_W-1:0] POS_DAY_TENS   = 5'd0;
    localparam logic [POS_W-1:0] POS_DAY_UNITS  = 5'd1;
    localparam logic [POS_W-1:0] POS_SEP_DATE_A = 5'd2;
    localparam logic [POS_W-1:0] POS_MON_TENS   = 5'd3;
    localparam logic [POS_W-1:0] POS_MON_UNITS  = 5'd4;
    localparam logic [POS_W-1:0] POS_SEP_DATE_B = 5'd5;
    localparam logic [POS_W-1:0] POS_YEAR_K     = 5'd6;
    localparam logic [POS_W-1:0] POS_YEAR_H     = 5'd7;
    localparam logic [POS_W-1:0] POS_YEAR_T     = 5'd8;
    localparam logic [POS_W-1:0] POS_YEAR_U     = 5'd9;
    localparam logic [POS_W-1:0] POS_HOUR_TENS  = 5'd10;
    localparam logic [POS_W-1:0] POS_HOUR_UNITS = 5'd11;
    localparam logic [POS_W-1:0] POS_SEP_TIME_A = 5'd12;
    localparam logic [POS_W-1:0] POS_MIN_TENS   = 5'd13;
    localparam logic [POS_W-1:0] POS_MIN_UNITS  = 5'd14;
    localparam logic [POS_W-1:0] POS_SEP_TIME_B = 5'd15;
    localparam logic [POS_W-1:0] POS_SEC_TENS   = 5'd16;
    localparam logic [POS_W-1:0] POS_SEC_UNITS  = 5'd17;

    typedef struct packed {
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_time;

    typedef struct packed {
        logic                  fast_mode;
        logic [PERIOD_W-1:0]   normal_period;
        logic [PERIOD_W-1:0]   fast_period;
        logic [PRESCALE_W-1:0] ticks_per_second;
    } t_cfg;

    typedef struct packed {
        t_time                 tm;
        logic [PERIOD_W-1:0]   record_count;
        logic [PRESCALE_W-1:0] prescale_count;
        logic [POS_W-1:0]      edit_pos;
        logic                  edit_on;
    } t_state;

    typedef struct packed {
        t_time            tm;
        logic             record_pulse;
        logic             minute_pulse;
        logic             day_pulse;
        logic             editing;
        logic [POS_W-1:0] cursor;
    } t_result;

endpackage

// ----- sv/rtc_calendar_with_digit_set_core.sv -----
`timescale 1ns / 1ps

// Real-time clock and calendar with decimal digit editing.
// Input channel (i_in_valid / o_in_ready) carries one request: a tick, a digit
// key or a begin-editing command. Every accepted request gives exactly one
// result on the output channel (o_out_valid / i_out_ready): the time and date
// after the request, the record, minute and day pulses, and the edit cursor.
// Each result is registered, in the result register or, on a stall, the skid entry.
// Throughput: one request per cycle while o_in_ready is high; the whole update
// (counters, rollover cascade, digit replacement) is one pass of logic between
// the state registers and the result register.
// Results sit in a two-entry output buffer (result register plus skid entry).
// When the receiver stalls, one more request is still taken; o_in_ready drops
// only while both entries are full.
// Configuration writes (i_cfg_valid / o_cfg_ready, index and data) are always
// taken and should be issued while no request is in flight.
// Reset (i_rst_n low, synchronous) empties the buffer, clears the counters,
// sets the date to 14.04.2023 00:00:00 and loads the default periods.
module rtc_calendar_with_digit_set_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rtccal_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtccal_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_cmd,
    input  logic [3:0]                         i_key_digit,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rtccal_pkg::FIELD_W-1:0]     o_cur_second,
    output logic [rtccal_pkg::FIELD_W-1:0]     o_cur_minute,
    output logic [rtccal_pkg::FIELD_W-1:0]     o_cur_hour,
    output logic [rtccal_pkg::FIELD_W-1:0]     o_cur_day,
    output logic [rtccal_pkg::FIELD_W-1:0]     o_cur_month,
    output logic [rtccal_pkg::YEAR_W-1:0]      o_cur_year,
    output logic                               o_record_pulse,
    output logic                               o_minute_pulse,
    output logic                               o_day_pulse,
    output logic                               o_editing,
    output logic [rtccal_pkg::POS_W-1:0]       o_cursor
);
    import rtccal_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;
    logic    in_fire;
    logic    out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_vld;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;

    rtccal_step u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_cmd       (i_cmd),
        .i_key_digit (i_key_digit),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_mode        <= 1'b0;
            r_cfg.normal_period    <= RST_NORMAL_PERIOD;
            r_cfg.fast_period      <= RST_FAST_PERIOD;
            r_cfg.ticks_per_second <= RST_TICKS_PER_SEC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FAST_MODE:     r_cfg.fast_mode        <= i_cfg_data[0];
                CFG_NORMAL_PERIOD: r_cfg.normal_period    <= i_cfg_data[PERIOD_W-1:0];
                CFG_FAST_PERIOD:   r_cfg.fast_period      <= i_cfg_data[PERIOD_W-1:0];
                CFG_TICKS_PER_SEC: r_cfg.ticks_per_second <= i_cfg_data[PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tm.second     <= '0;
            r_state.tm.minute     <= '0;
            r_state.tm.hour       <= '0;
            r_state.tm.day        <= RST_DAY;
            r_state.tm.month      <= RST_MONTH;
            r_state.tm.year       <= RST_YEAR;
            r_state.record_count  <= '0;
            r_state.prescale_count <= '0;
            r_state.edit_pos      <= '0;
            r_state.edit_on       <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // two-entry output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld  <= r_skid_vld || in_fire;
            r_skid_vld <= 1'b0;
        end else if (in_fire) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : n_result;
        end
        if (in_fire && !out_free) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_cur_second   = r_out.tm.second;
    assign o_cur_minute   = r_out.tm.minute;
    assign o_cur_hour     = r_out.tm.hour;
    assign o_cur_day      = r_out.tm.day;
    assign o_cur_month    = r_out.tm.month;
    assign o_cur_year     = r_out.tm.year;
    assign o_record_pulse = r_out.record_pulse;
    assign o_minute_pulse = r_out.minute_pulse;
    assign o_day_pulse    = r_out.day_pulse;
    assign o_editing      = r_out.editing;
    assign o_cursor       = r_out.cursor;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds a result while the result register is empty");

    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out_valid)
        else $error("accepted request left no result");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_out_ready) |=> (o_out_valid && !r_skid_vld))
        else $error("skid entry not moved into the result register");

    a_cursor_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.edit_on |-> (r_state.edit_pos == POS_DAY_TENS))
        else $error("cursor not at first digit while not editing");

    a_cursor_on_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.edit_pos <= POS_SEC_UNITS) && (r_state.edit_pos != POS_SEP_DATE_A)
        && (r_state.edit_pos != POS_SEP_DATE_B) && (r_state.edit_pos != POS_SEP_TIME_A)
        && (r_state.edit_pos != POS_SEP_TIME_B))
        else $error("cursor on a separator or past the last digit");

endmodule

// ----- sv/rtccal_step.sv -----
`timescale 1ns / 1ps

module rtccal_step (
    input  rtccal_pkg::t_state  i_state,
    input  rtccal_pkg::t_cfg    i_cfg,
    input  logic [1:0]          i_cmd,
    input  logic [3:0]          i_key_digit,
    output rtccal_pkg::t_state  o_state,
    output rtccal_pkg::t_result o_result
);
    import rtccal_pkg::*;

    // remainder by ten of a 7-bit value, reciprocal 205 / 2^11
    function automatic logic [FIELD_W-1:0] mod10_7(input logic [FIELD_W-1:0] v);
        logic [14:0] p;
        logic [3:0]  q;
        p = {8'd0, v} * 15'd205;
        q = p[14:11];
        mod10_7 = v - {3'd0, q} * 7'd10;
    endfunction

    function automatic logic [FIELD_W-1:0] set_tens(input logic [FIELD_W-1:0] v,
                                                    input logic [3:0] d);
        set_tens = mod10_7(v) + {3'd0, d} * 7'd10;
    endfunction

    function automatic logic [FIELD_W-1:0] set_units(input logic [FIELD_W-1:0] v,
                                                     input logic [3:0] d);
        set_units = v - mod10_7(v) + {3'd0, d};
    endfunction

    // month length, zero for a month that does not exist
    function automatic logic [4:0] month_days(input logic [FIELD_W-1:0] m, input logic leap);
        case (m) inside
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: month_days = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    month_days = 5'd30;
            7'd2:    month_days = leap ? 5'd29 : 5'd28;
            default: month_days = 5'd0;
        endcase
    endfunction

    logic [3:0]          digit;
    logic [29:0]         prod10;
    logic [26:0]         prod100;
    logic [27:0]         prod1000;
    logic [13:0]         prod25;
    logic [YEAR_W-1:0]   y10, y100, y1000;
    logic [YEAR_W-1:0]   yd;
    logic                mult25;
    logic                leap;
    logic [4:0]          dim;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W:0]   rc;
    logic [PRESCALE_W:0] pc;
    logic [POS_W-1:0]    np;
    logic                rp, mp, dp;
    t_state              n;

    // year digit split: each quotient from one constant reciprocal
    always_comb begin
        prod10   = {16'd0, i_state.tm.year} * 30'd52429;
        prod100  = {13'd0, i_state.tm.year} * 27'd5243;
        prod1000 = {14'd0, i_state.tm.year} * 28'd8389;
        y10      = {3'd0, prod10[29:19]} * 14'd10;
        y100     = {6'd0, prod100[26:19]} * 14'd100;
        y1000    = {9'd0, prod1000[27:23]} * 14'd1000;
        // divisible by 25 via the inverse of 25 modulo 2^14
        prod25   = i_state.tm.year * 14'd7209;
        mult25   = (prod25 <= 14'd655);
        leap     = (i_state.tm.year[1:0] == 2'd0)
                   && (!mult25 || (i_state.tm.year[3:0] == 4'd0));
        dim      = month_days(i_state.tm.month, leap);
    end

    always_comb begin
        n      = i_state;
        rp     = 1'b0;
        mp     = 1'b0;
        dp     = 1'b0;
        digit  = (i_key_digit > 4'd9) ? 4'd9 : i_key_digit;
        yd     = {10'd0, digit};
        period = i_cfg.fast_mode ? i_cfg.fast_period : i_cfg.normal_period;
        rc     = {1'b0, i_state.record_count} + {{PERIOD_W{1'b0}}, 1'b1};
        pc     = {1'b0, i_state.prescale_count} + {{PRESCALE_W{1'b0}}, 1'b1};
        np     = i_state.edit_pos + 5'd1;

        unique case (i_cmd)
            CMD_TICK: begin
                if (rc >= {1'b0, period}) begin
                    n.record_count = '0;
                    rp = 1'b1;
                end else begin
                    n.record_count = rc[PERIOD_W-1:0];
                end
                if (pc >= {1'b0, i_cfg.ticks_per_second} || i_cfg.fast_mode) begin
                    n.prescale_count = '0;
                    // rollover cascade
                    if ({1'b0, i_state.tm.second} + 8'd1 < 8'd60) begin
                        n.tm.second = i_state.tm.second + 7'd1;
                    end else begin
                        n.tm.second = '0;
                        mp = 1'b1;
                        if ({1'b0, i_state.tm.minute} + 8'd1 < 8'd60) begin
                            n.tm.minute = i_state.tm.minute + 7'd1;
                        end else begin
                            n.tm.minute = '0;
                            if ({1'b0, i_state.tm.hour} + 8'd1 < 8'd24) begin
                                n.tm.hour = i_state.tm.hour + 7'd1;
                            end else begin
                                n.tm.hour = '0;
                                dp = 1'b1;
                                if ({1'b0, i_state.tm.day} + 8'd1 <= {3'd0, dim}) begin
                                    n.tm.day = i_state.tm.day + 7'd1;
                                end else begin
                                    n.tm.day = 7'd1;
                                    if ({1'b0, i_state.tm.month} + 8'd1 <= 8'd12) begin
                                        n.tm.month = i_state.tm.month + 7'd1;
                                    end else begin
                                        n.tm.month = 7'd1;
                                        n.tm.year  = (i_state.tm.year >= 14'd9999) ? '0
                                                     : i_state.tm.year + 14'd1;
                                    end
                                end
                            end
                        end
                    end
                end else begin
                    n.prescale_count = pc[PRESCALE_W-1:0];
                end
            end
            CMD_KEY: begin
                if (i_state.edit_on) begin
                    case (i_state.edit_pos)
                        POS_DAY_TENS:   n.tm.day    = set_tens(i_state.tm.day, digit);
                        POS_DAY_UNITS:  n.tm.day    = set_units(i_state.tm.day, digit);
                        POS_MON_TENS:   n.tm.month  = set_tens(i_state.tm.month, digit);
                        POS_MON_UNITS:  n.tm.month  = set_units(i_state.tm.month, digit);
                        POS_YEAR_K:     n.tm.year   = (i_state.tm.year - y1000)
                                                      + yd * 14'd1000;
                        POS_YEAR_H:     n.tm.year   = y1000 + (i_state.tm.year - y100)
                                                      + yd * 14'd100;
                        POS_YEAR_T:     n.tm.year   = y100 + (i_state.tm.year - y10)
                                                      + yd * 14'd10;
                        POS_YEAR_U:     n.tm.year   = y10 + yd;
                        POS_HOUR_TENS:  n.tm.hour   = set_tens(i_state.tm.hour, digit);
                        POS_HOUR_UNITS: n.tm.hour   = set_units(i_state.tm.hour, digit);
                        POS_MIN_TENS:   n.tm.minute = set_tens(i_state.tm.minute, digit);
                        POS_MIN_UNITS:  n.tm.minute = set_units(i_state.tm.minute, digit);
                        POS_SEC_TENS:   n.tm.second = set_tens(i_state.tm.second, digit);
                        POS_SEC_UNITS:  n.tm.second = set_units(i_state.tm.second, digit);
                        default: ;
                    endcase
                    if (np == POS_SEP_DATE_A || np == POS_SEP_DATE_B
                            || np == POS_SEP_TIME_A || np == POS_SEP_TIME_B) begin
                        np = np + 5'd1;
                    end
                    if (np > POS_SEC_UNITS) begin
                        n.edit_pos = '0;
                        n.edit_on  = 1'b0;
                    end else begin
                        n.edit_pos = np;
                    end
                end
            end
            CMD_BEGIN: begin
                n.edit_on  = 1'b1;
                n.edit_pos = POS_DAY_TENS;
            end
            default: ;
        endcase
    end

    assign o_state = n;

    always_comb begin
        o_result.tm           = n.tm;
        o_result.record_pulse = rp;
        o_result.minute_pulse = mp;
        o_result.day_pulse    = dp;
        o_result.editing      = n.edit_on;
        o_result.cursor       = n.edit_pos;
    end

endmodule

// ----- test/rtc_calendar_with_digit_set_core_tb.sv -----
`timescale 1ns / 1ps

module rtc_calendar_with_digit_set_core_tb;
    import rtccal_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STUCK_LIMIT = 1000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_cmd;
    logic [3:0]            i_key_digit;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [FIELD_W-1:0]    o_cur_second;
    logic [FIELD_W-1:0]    o_cur_minute;
    logic [FIELD_W-1:0]    o_cur_hour;
    logic [FIELD_W-1:0]    o_cur_day;
    logic [FIELD_W-1:0]    o_cur_month;
    logic [YEAR_W-1:0]     o_cur_year;
    logic                  o_record_pulse;
    logic                  o_minute_pulse;
    logic                  o_day_pulse;
    logic                  o_editing;
    logic [POS_W-1:0]      o_cursor;

    rtc_calendar_with_digit_set_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_key_digit    (i_key_digit),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cur_second   (o_cur_second),
        .o_cur_minute   (o_cur_minute),
        .o_cur_hour     (o_cur_hour),
        .o_cur_day      (o_cur_day),
        .o_cur_month    (o_cur_month),
        .o_cur_year     (o_cur_year),
        .o_record_pulse (o_record_pulse),
        .o_minute_pulse (o_minute_pulse),
        .o_day_pulse    (o_day_pulse),
        .o_editing      (o_editing),
        .o_cursor       (o_cursor)
    );

    // calendar model state
    t_cfg                  cal_cfg;
    t_time                 cal;
    logic [PERIOD_W-1:0]   rec_ticks;
    logic [PRESCALE_W-1:0] pre_ticks;
    logic [POS_W-1:0]      cursor_pos;
    logic                  edit_active;

    t_result readings_due[$];

    int  mismatch_count = 0;
    int  effective_requests = 0;
    int  tick_count = 0;
    int  key_count = 0;
    int  record_seen = 0;
    int  minute_seen = 0;
    int  day_seen = 0;
    int  cfg_writes = 0;
    int  stuck_cycles = 0;
    int  stall_left = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int month_length(int m, int y);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int tens_set(int v, int d);
        return (v % 10) + d * 10;
    endfunction

    function automatic int units_set(int v, int d);
        return v - (v % 10) + d;
    endfunction

    function automatic void advance_clock(output bit min_roll, output bit day_roll);
        int yr;
        min_roll = 1'b0;
        day_roll = 1'b0;
        if (int'(cal.second) + 1 < 60) begin
            cal.second = cal.second + FIELD_W'(1);
            return;
        end
        cal.second = '0;
        min_roll = 1'b1;
        if (int'(cal.minute) + 1 < 60) begin
            cal.minute = cal.minute + FIELD_W'(1);
            return;
        end
        cal.minute = '0;
        if (int'(cal.hour) + 1 < 24) begin
            cal.hour = cal.hour + FIELD_W'(1);
            return;
        end
        cal.hour = '0;
        day_roll = 1'b1;
        if (int'(cal.day) + 1 <= month_length(int'(cal.month), int'(cal.year))) begin
            cal.day = cal.day + FIELD_W'(1);
            return;
        end
        cal.day = FIELD_W'(1);
        if (int'(cal.month) + 1 <= 12) begin
            cal.month = cal.month + FIELD_W'(1);
            return;
        end
        cal.month = FIELD_W'(1);
        yr = int'(cal.year);
        cal.year = (yr >= 9999) ? '0 : YEAR_W'(yr + 1);
    endfunction

    function automatic void put_digit(int d);
        int yr;
        yr = int'(cal.year);
        case (cursor_pos)
            POS_DAY_TENS:   cal.day    = FIELD_W'(tens_set(int'(cal.day), d));
            POS_DAY_UNITS:  cal.day    = FIELD_W'(units_set(int'(cal.day), d));
            POS_MON_TENS:   cal.month  = FIELD_W'(tens_set(int'(cal.month), d));
            POS_MON_UNITS:  cal.month  = FIELD_W'(units_set(int'(cal.month), d));
            POS_YEAR_K:     cal.year   = YEAR_W'(yr % 1000 + d * 1000);
            POS_YEAR_H:     cal.year   = YEAR_W'(yr - ((yr / 100) % 10) * 100 + d * 100);
            POS_YEAR_T:     cal.year   = YEAR_W'(yr - ((yr / 10) % 10) * 10 + d * 10);
            POS_YEAR_U:     cal.year   = YEAR_W'(units_set(yr, d));
            POS_HOUR_TENS:  cal.hour   = FIELD_W'(tens_set(int'(cal.hour), d));
            POS_HOUR_UNITS: cal.hour   = FIELD_W'(units_set(int'(cal.hour), d));
            POS_MIN_TENS:   cal.minute = FIELD_W'(tens_set(int'(cal.minute), d));
            POS_MIN_UNITS:  cal.minute = FIELD_W'(units_set(int'(cal.minute), d));
            POS_SEC_TENS:   cal.second = FIELD_W'(tens_set(int'(cal.second), d));
            POS_SEC_UNITS:  cal.second = FIELD_W'(units_set(int'(cal.second), d));
            default: ;
        endcase
        cursor_pos = cursor_pos + POS_W'(1);
        if (cursor_pos == POS_SEP_DATE_A || cursor_pos == POS_SEP_DATE_B ||
            cursor_pos == POS_SEP_TIME_A || cursor_pos == POS_SEP_TIME_B)
            cursor_pos = cursor_pos + POS_W'(1);
        if (cursor_pos > POS_SEC_UNITS) begin
            cursor_pos  = POS_DAY_TENS;
            edit_active = 1'b0;
        end
    endfunction

    function automatic t_result predict_reading(logic [1:0] cmd, logic [3:0] key);
        t_result r;
        int      period;
        int      rc;
        int      pc;
        int      d;
        bit      mr;
        bit      dr;
        r = '0;
        d = (key > 4'd9) ? 9 : int'(key);
        if (cmd == CMD_TICK || cmd == CMD_BEGIN || (cmd == CMD_KEY && edit_active))
            effective_requests++;
        case (cmd)
            CMD_TICK: begin
                tick_count++;
                period = cal_cfg.fast_mode ? int'(cal_cfg.fast_period)
                                           : int'(cal_cfg.normal_period);
                rc = int'(rec_ticks) + 1;
                pc = int'(pre_ticks) + 1;
                if (rc >= period) begin
                    rc = 0;
                    r.record_pulse = 1'b1;
                end
                rec_ticks = PERIOD_W'(rc);
                if (pc >= int'(cal_cfg.ticks_per_second) || cal_cfg.fast_mode) begin
                    pc = 0;
                    advance_clock(mr, dr);
                    r.minute_pulse = mr;
                    r.day_pulse    = dr;
                end
                pre_ticks = PRESCALE_W'(pc);
            end
            CMD_KEY: begin
                if (edit_active) begin
                    key_count++;
                    put_digit(d);
                end
            end
            CMD_BEGIN: begin
                edit_active = 1'b1;
                cursor_pos  = POS_DAY_TENS;
            end
            default: ;
        endcase
        record_seen += int'(r.record_pulse);
        minute_seen += int'(r.minute_pulse);
        day_seen    += int'(r.day_pulse);
        r.tm      = cal;
        r.editing = edit_active;
        r.cursor  = cursor_pos;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [13:0] want,
                                 input logic [13:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (readings_due.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                want = readings_due.pop_front();
                compare_field("cur_second", 14'(want.tm.second), 14'(o_cur_second));
                compare_field("cur_minute", 14'(want.tm.minute), 14'(o_cur_minute));
                compare_field("cur_hour", 14'(want.tm.hour), 14'(o_cur_hour));
                compare_field("cur_day", 14'(want.tm.day), 14'(o_cur_day));
                compare_field("cur_month", 14'(want.tm.month), 14'(o_cur_month));
                compare_field("cur_year", want.tm.year, o_cur_year);
                compare_field("record_pulse", 14'(want.record_pulse), 14'(o_record_pulse));
                compare_field("minute_pulse", 14'(want.minute_pulse), 14'(o_minute_pulse));
                compare_field("day_pulse", 14'(want.day_pulse), 14'(o_day_pulse));
                compare_field("editing", 14'(want.editing), 14'(o_editing));
                compare_field("cursor", 14'(want.cursor), 14'(o_cursor));
            end
        end
    end

    // receiver stalls in random bursts, started only while rx_idle_on is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
                $display("rtc_calendar_with_digit_set_core: mismatch");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [3:0] key);
        int gap;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_key_digit <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        readings_due.push_back(predict_reading(cmd, key));
    endtask

    // hold off requests until every result is back
    task automatic drain_pending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FAST_MODE:     cal_cfg.fast_mode        = value[0];
            CFG_NORMAL_PERIOD: cal_cfg.normal_period    = value[PERIOD_W-1:0];
            CFG_FAST_PERIOD:   cal_cfg.fast_period      = value[PERIOD_W-1:0];
            CFG_TICKS_PER_SEC: cal_cfg.ticks_per_second = value[PRESCALE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int fast, input int normal_p, input int fast_p,
                              input int tps);
        drain_pending();
        write_reg(CFG_FAST_MODE, fast);
        write_reg(CFG_NORMAL_PERIOD, normal_p);
        write_reg(CFG_FAST_PERIOD, fast_p);
        write_reg(CFG_TICKS_PER_SEC, tps);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(CMD_TICK, 4'($urandom_range(0, 15)));
    endtask

    // full edit session: begin then fourteen digit keys, sometimes with ticks between
    task automatic enter_clock(input int dd, input int mm, input int yy, input int hh,
                               input int mi, input int ss);
        int dial[14];
        int k;
        dial = '{dd / 10, dd % 10, mm / 10, mm % 10, yy / 1000, (yy / 100) % 10,
                 (yy / 10) % 10, yy % 10, hh / 10, hh % 10, mi / 10, mi % 10,
                 ss / 10, ss % 10};
        send_request(CMD_BEGIN, 4'($urandom_range(0, 15)));
        for (int i = 0; i < 14; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_request(CMD_TICK, 4'd0);
            k = dial[i];
            // digits above nine clamp to nine
            if (k == 9 && $urandom_range(0, 2) == 0)
                k = $urandom_range(10, 15);
            send_request(CMD_KEY, 4'(k));
        end
    endtask

    task automatic random_clock_edit();
        int dd, mm, yy, hh, mi, ss;
        dd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(27, 31);
        case ($urandom_range(0, 7))
            0:       mm = 0;
            1:       mm = $urandom_range(13, 99);
            2, 3:    mm = 2;
            default: mm = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0:       yy = 9999;
            1:       yy = 1900;
            2:       yy = 2000;
            3:       yy = 2100;
            4:       yy = 4 * $urandom_range(0, 2499);
            5:       yy = 2023;
            default: yy = $urandom_range(0, 9999);
        endcase
        hh = ($urandom_range(0, 3) < 3) ? 23 : $urandom_range(0, 99);
        mi = ($urandom_range(0, 3) < 3) ? 59 : $urandom_range(0, 99);
        ss = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(50, 59);
        enter_clock(dd, mm, yy, hh, mi, ss);
        send_ticks($urandom_range(1, 30));
    endtask

    task automatic random_phase(input int n_items);
        int stop_at;
        int pick;
        stop_at = effective_requests + n_items;
        while (effective_requests < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick == 0) begin
                drain_pending();
            end else if (pick < 45) begin
                random_clock_edit();
            end else if (pick < 60) begin
                // abandoned edit: a few keys, then something else
                send_request(CMD_BEGIN, 4'($urandom_range(0, 15)));
                repeat ($urandom_range(0, 13))
                    send_request(CMD_KEY, 4'($urandom_range(0, 15)));
            end else if (pick < 85) begin
                send_ticks($urandom_range(1, 20));
            end else begin
                repeat ($urandom_range(1, 5))
                    send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic test_ignored_requests();
        send_request(CMD_UNUSED, 4'd15);
        send_request(CMD_KEY, 4'd7);
        send_request(CMD_TICK, 4'd0);
    endtask

    // 31.13.9999 23:59:99 then one tick: every field rolls over at once
    task automatic test_full_rollover();
        int dial[14];
        dial = '{3, 1, 1, 3, 9, 9, 9, 9, 2, 3, 5, 9, 9, 15};
        set_config(1, 1800000, 1, 1800);
        send_request(CMD_BEGIN, 4'd0);
        send_request(CMD_KEY, 4'd0);
        send_request(CMD_KEY, 4'd5);
        // restart in the middle of an edit
        send_request(CMD_BEGIN, 4'd0);
        for (int i = 0; i < 14; i++) begin
            send_request(CMD_KEY, 4'(dial[i]));
            if (i == 5)
                send_request(CMD_TICK, 4'd0);
        end
        send_request(CMD_TICK, 4'd0);
    endtask

    task automatic test_normal_prescaler();
        set_config(0, 3, 1000, 1);
        random_phase(300);
    endtask

    task automatic test_period_below_one();
        set_config(0, 0, 0, 0);
        random_phase(150);
        drain_pending();
        write_reg(CFG_FAST_MODE, 1);
        random_phase(100);
    endtask

    task automatic test_max_periods();
        set_config(0, 2097151, 2097151, 2047);
        random_phase(150);
        drain_pending();
        write_reg(CFG_FAST_MODE, 1);
        random_phase(250);
    endtask

    task automatic test_fast_mode_random();
        set_config(1, $urandom_range(1, 40), $urandom_range(2, 60), $urandom_range(1, 2047));
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        random_phase(150);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        random_phase(250);
    endtask

    task automatic test_back_to_back();
        set_config($urandom_range(0, 1), $urandom_range(1, 50), $urandom_range(1, 50),
                   $urandom_range(1, 3));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_phase(650);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_cmd       = CMD_TICK;
        i_key_digit = '0;
        i_out_ready = 1'b0;

        cal_cfg.fast_mode        = 1'b0;
        cal_cfg.normal_period    = RST_NORMAL_PERIOD;
        cal_cfg.fast_period      = RST_FAST_PERIOD;
        cal_cfg.ticks_per_second = RST_TICKS_PER_SEC;
        cal.second  = '0;
        cal.minute  = '0;
        cal.hour    = '0;
        cal.day     = RST_DAY;
        cal.month   = RST_MONTH;
        cal.year    = RST_YEAR;
        rec_ticks   = '0;
        pre_ticks   = '0;
        cursor_pos  = POS_DAY_TENS;
        edit_active = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_requests();
        test_full_rollover();
        test_normal_prescaler();
        test_period_below_one();
        test_max_periods();
        test_fast_mode_random();
        test_back_to_back();

        drain_pending();
        repeat (4) @(posedge i_clk);
        $display("%0d requests (%0d ticks, %0d digit keys), %0d config writes",
                 effective_requests, tick_count, key_count, cfg_writes);
        $display("pulses seen: %0d record, %0d minute, %0d day; %0d mismatches",
                 record_seen, minute_seen, day_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("rtc_calendar_with_digit_set_core: match");
        else
            $display("rtc_calendar_with_digit_set_core: mismatch");
        $finish;
    end

endmodule
